// ===== sv/text_packet_receiver_defines.svh =====
// ---------------------------------------------------------------------------
// text_packet_receiver_defines
// Assertion macros used by the packet receiver back end (trp_back).
// ---------------------------------------------------------------------------
`ifndef TEXT_PACKET_RECEIVER_DEFINES_SVH
`define TEXT_PACKET_RECEIVER_DEFINES_SVH

// Same-cycle implication, clocked on clk and idle during reset
`define TRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and idle during reset
`define TRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/trp_pkg.sv =====
// ---------------------------------------------------------------------------
// trp_pkg
// Beat types, byte codes and field widths of the text packet receiver.
// ---------------------------------------------------------------------------
package trp_pkg;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 6;
  localparam int LEN_W  = 7;

  // Framing bytes
  localparam logic [BYTE_W-1:0] START_BYTE = 8'h40;
  localparam logic [BYTE_W-1:0] CR_BYTE    = 8'h0D;
  localparam logic [BYTE_W-1:0] LF_BYTE    = 8'h0A;

  // Input beat operation codes
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic [IDX_W-1:0]  byte_index;
    logic [LEN_W-1:0]  packet_length;
    logic              overflowed;
    logic              last;
  } out_item_t;

  // Emit command passed from front to back
  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic             overflowed;
  } cmd_t;

  // Payload store write port
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } mem_wr_t;

endpackage

// ===== sv/trp_front.sv =====
// ---------------------------------------------------------------------------
// trp_front
// Framing state machine: hunts for start, collects payload, waits for LF,
// and queues an emit command per completed packet.
// ---------------------------------------------------------------------------
module trp_front #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  trp_pkg::in_item_t in_data,
  input  logic              busy,
  input  logic              q_full,
  output logic              cmd_push,
  output trp_pkg::cmd_t     cmd_data,
  output trp_pkg::mem_wr_t  mem_wr
);
  import trp_pkg::*;

  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_COLLECT = 2'd1,
    PH_WAIT_LF = 2'd2
  } phase_t;

  phase_t        phase;
  logic [CW-1:0] fill_count;
  logic          packet_held;
  logic          overflow_seen;

  logic is_byte, is_cr, is_lf, is_start, room;
  logic want_write, want_emit, fire;

  // Classify the beat and decide whether it can go now
  always_comb begin
    is_byte    = (in_data.operation == OP_BYTE);
    is_cr      = (in_data.rx_byte == CR_BYTE);
    is_lf      = (in_data.rx_byte == LF_BYTE);
    is_start   = (in_data.rx_byte == START_BYTE);
    room       = (fill_count < CW'(BUFFER_DEPTH));
    want_write = is_byte && (phase == PH_COLLECT) && !is_cr && room;
    want_emit  = is_byte && (phase == PH_WAIT_LF) && is_lf;
    // store writes wait until the back has drained the previous packet
    in_ready   = !(want_write && busy) && !(want_emit && q_full);
    fire       = in_valid && in_ready;
  end

  // Store write and emit command
  always_comb begin
    mem_wr.en           = fire && want_write;
    mem_wr.addr         = IDX_W'(fill_count);
    mem_wr.data         = in_data.rx_byte;
    cmd_push            = fire && want_emit;
    cmd_data.length     = LEN_W'(fill_count);
    cmd_data.overflowed = overflow_seen;
  end

  // Framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      fill_count    <= '0;
      packet_held   <= 1'b0;
      overflow_seen <= 1'b0;
    end else if (fire) begin
      if (!is_byte) begin
        packet_held <= 1'b0;
      end else begin
        unique case (phase)
          PH_COLLECT: begin
            if (is_cr) begin
              phase <= PH_WAIT_LF;
            end else if (room) begin
              fill_count <= fill_count + CW'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
          end
          PH_WAIT_LF: begin
            if (is_lf) begin
              phase       <= PH_HUNT;
              packet_held <= 1'b1;
            end
          end
          default: begin
            if (is_start && !packet_held) begin
              phase         <= PH_COLLECT;
              fill_count    <= '0;
              overflow_seen <= 1'b0;
            end else begin
              phase <= PH_HUNT;
            end
          end
        endcase
      end
    end
  end

endmodule

// ===== sv/trp_cmd_queue.sv =====
// ---------------------------------------------------------------------------
// trp_cmd_queue
// Two-entry queue of emit commands between front and back.
// ---------------------------------------------------------------------------
module trp_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  trp_pkg::cmd_t push_data,
  output logic          full,
  output logic          valid,
  input  logic          pop,
  output trp_pkg::cmd_t pop_data
);
  import trp_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign valid    = (count != 2'd0);
  assign pop_data = entries[rd_ptr];

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== sv/trp_back.sv =====
// ---------------------------------------------------------------------------
// trp_back
// Payload store and emitter: replays a stored packet as a run of result
// beats through a read stage and an output register.
// ---------------------------------------------------------------------------
`include "text_packet_receiver_defines.svh"

module trp_back #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  trp_pkg::mem_wr_t   mem_wr,
  input  logic               cmd_valid,
  input  trp_pkg::cmd_t      cmd_data,
  output logic               cmd_pop,
  output logic               active,
  output logic               out_valid,
  input  logic               out_ready,
  output trp_pkg::out_item_t out_data
);
  import trp_pkg::*;

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic [BYTE_W-1:0] mem [BUFFER_DEPTH];

  logic [LEN_W-1:0]  len;
  logic              ovf;
  logic [LEN_W-1:0]  idx;
  logic              rd_valid;
  out_item_t         rd_meta;

  logic load, issue, rd_move, cur_last;

  // Sequencer and pipeline advance
  always_comb begin
    load     = !active && cmd_valid;
    cmd_pop  = load;
    rd_move  = rd_valid && (!out_valid || out_ready);
    issue    = active && (!rd_valid || rd_move);
    cur_last = (len == '0) || ((idx + LEN_W'(1)) == len);
  end

  // Payload store write
  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[mem_wr.addr[AW-1:0]] <= mem_wr.data;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        active <= 1'b1;
      end else if (issue && cur_last) begin
        active <= 1'b0;
      end
      if (issue) begin
        rd_valid <= 1'b1;
      end else if (rd_move) begin
        rd_valid <= 1'b0;
      end
      if (rd_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload path: command, read stage, output register
  always_ff @(posedge clk) begin
    if (load) begin
      len <= cmd_data.length;
      ovf <= cmd_data.overflowed;
      idx <= '0;
    end
    if (issue) begin
      idx                   <= idx + LEN_W'(1);
      // an empty packet reports a zero byte
      rd_meta.payload_byte  <= (len == '0) ? '0 : mem[idx[AW-1:0]];
      rd_meta.byte_index    <= IDX_W'(idx);
      rd_meta.packet_length <= len;
      rd_meta.overflowed    <= ovf;
      rd_meta.last          <= cur_last;
    end
    if (rd_move) begin
      out_data <= rd_meta;
    end
  end

  // Checks
  `TRP_ASSERT_NOW(a_no_write_while_draining, mem_wr.en, !active && !cmd_valid, "early store write")
  `TRP_ASSERT_NOW(a_more_beats_follow, out_valid && !out_data.last, active || rd_valid, "no last")
  `TRP_ASSERT_NOW(a_len_in_range, active, len <= LEN_W'(BUFFER_DEPTH), "length too large")
  `TRP_ASSERT_NEXT(a_last_ends_run, issue && cur_last && !load, !active, "active after last")

endmodule

// ===== sv/text_packet_receiver.sv =====
// ---------------------------------------------------------------------------
// text_packet_receiver
// Deframes '@' payload CR LF packets from a received byte stream.
// ---------------------------------------------------------------------------
// Input beats carry either a received byte or a release of the held packet.
// Output beats replay a completed packet, one per payload byte, with its
// index, length, overflow flag and a last mark; an empty packet gives one
// beat with length 0.
// On LF an emit command enters a two-entry queue; the back loads it, reads
// the first byte into its read stage and moves it to the output register,
// and further beats follow one per cycle while out_ready stays high.
// A payload byte waits at in_ready low while an earlier packet is still
// draining, since it would overwrite the store; an LF waits while the queue
// is full. Other beats go through at once.
// When out_ready is low the output register and read stage hold their
// beats and the run pauses; nothing is dropped.
// Reset clears the framing state, queue and emitter; the payload store
// needs no clearing, since only bytes of the current packet are read.
// ---------------------------------------------------------------------------
module text_packet_receiver #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  trp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output trp_pkg::out_item_t out_data
);
  import trp_pkg::*;

  logic    cmd_push, cmd_pop, q_full, q_valid, back_active, busy;
  cmd_t    push_cmd, pop_cmd;
  mem_wr_t mem_wr;

  // A packet is in flight while a command waits or the back is replaying
  assign busy = q_valid || back_active;

  trp_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .busy     (busy),
    .q_full   (q_full),
    .cmd_push (cmd_push),
    .cmd_data (push_cmd),
    .mem_wr   (mem_wr)
  );

  trp_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (push_cmd),
    .full      (q_full),
    .valid     (q_valid),
    .pop       (cmd_pop),
    .pop_data  (pop_cmd)
  );

  trp_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .mem_wr    (mem_wr),
    .cmd_valid (q_valid),
    .cmd_data  (pop_cmd),
    .cmd_pop   (cmd_pop),
    .active    (back_active),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
